// File: hw/rtl/lmsd_pkg.sv
// Shared types, constants and colour decode for the LED matrix scan driver.
package lmsd_pkg;

    localparam int LINE_LENGTH = 64;
    localparam int HALF_LINES  = 16;
    localparam int SCAN_LIMIT  = 1024;

    localparam int COLOR_W    = 8;
    localparam int COL_W      = $clog2(LINE_LENGTH);
    localparam int HALF_W     = $clog2(HALF_LINES);
    localparam int LINE_W     = HALF_W + 1;
    localparam int BANK_DEPTH = HALF_LINES * LINE_LENGTH;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int POS_W      = $clog2(SCAN_LIMIT + 1);
    localparam int ROW_W      = 4;
    localparam int REQ_W      = 2;

    localparam logic [COLOR_W-1:0] OFF_CODE = 8'hFF;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } lmsd_req_t;

    // One bank access for a cycle
    typedef struct packed {
        logic               en;
        logic               we;
        logic [BANK_AW-1:0] addr;
        logic [COLOR_W-1:0] wdata;
    } lmsd_ram_req_t;

    // Item waiting on bank read data
    typedef struct packed {
        logic             valid;
        logic             is_read;
        logic             is_tick;
        logic             bank;
        logic             latch;
        logic [ROW_W-1:0] row;
        logic             clock_level;
    } lmsd_s1_t;

    // Colour code to RGB bits: bit 0 red, bit 1 green, bit 2 blue
    function automatic logic [2:0] color_decode(input logic [COLOR_W-1:0] code);
        logic [2:0] bits;
        begin
            unique case (code)
                8'd0:    bits = 3'b001;
                8'd1:    bits = 3'b100;
                8'd2:    bits = 3'b010;
                8'd3:    bits = 3'b101;
                8'd4:    bits = 3'b011;
                8'd5:    bits = 3'b110;
                8'd6:    bits = 3'b111;
                default: bits = 3'b000;
            endcase
            return bits;
        end
    endfunction

endpackage

// File: hw/rtl/lmsd_ram.sv
// Generic single-port RAM with registered read.
module lmsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read data holds while the port is idle
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lmsd_scan_ctrl.sv
// Input stage: clearing pass, scan position, shift clock and bank addressing.
module lmsd_scan_ctrl
    import lmsd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [REQ_W-1:0]     s_tuser,
    input  logic                 s1_take,
    output lmsd_s1_t             s1,
    output lmsd_ram_req_t        ram0_req,
    output lmsd_ram_req_t        ram1_req,
    output logic                 clear_busy
);

    logic                clear_busy_reg;
    logic [BANK_AW-1:0]  clear_cnt_reg;
    logic [BANK_AW-1:0]  clear_cnt_next;
    logic                clear_busy_next;
    logic                clock_pin_reg, clock_pin_next;
    logic [POS_W-1:0]    scan_pos_reg, scan_pos_next;
    lmsd_s1_t            s1_reg, s1_next, s1_new;

    logic                s_accept;
    lmsd_req_t           req;
    logic [LINE_W-1:0]   line_index;
    logic [COL_W-1:0]    position_index;
    logic [COLOR_W-1:0]  pixel_color;
    lmsd_ram_req_t       pix_req;
    logic [HALF_W-1:0]   scan_line;
    logic [COL_W-1:0]    scan_offs;

    assign req            = lmsd_req_t'(s_tuser);
    assign line_index     = s_tdata[LINE_W-1:0];
    assign position_index = s_tdata[LINE_W +: COL_W];
    assign pixel_color    = s_tdata[LINE_W + COL_W +: COLOR_W];

    assign scan_line = scan_pos_reg[COL_W +: HALF_W];
    assign scan_offs = scan_pos_reg[COL_W-1:0];

    assign s_tready   = !clear_busy_reg && (!s1_reg.valid || s1_take);
    assign s_accept   = s_tvalid && s_tready;
    assign s1         = s1_reg;
    assign clear_busy = clear_busy_reg;

    always_comb begin
        clear_cnt_next  = clear_cnt_reg;
        clear_busy_next = clear_busy_reg;
        if (clear_busy_reg) begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == BANK_AW'(BANK_DEPTH - 1)) begin
                clear_busy_next = 1'b0;
            end
        end
    end

    always_comb begin
        ram0_req       = '0;
        ram1_req       = '0;
        pix_req        = '0;
        pix_req.en     = 1'b1;
        pix_req.addr   = {line_index[HALF_W-1:0], position_index};
        pix_req.wdata  = pixel_color;
        clock_pin_next = clock_pin_reg;
        scan_pos_next  = scan_pos_reg;
        s1_new             = '0;
        s1_new.valid       = 1'b1;
        s1_new.bank        = line_index[HALF_W];
        s1_new.clock_level = clock_pin_reg;

        if (clear_busy_reg) begin
            ram0_req.en    = 1'b1;
            ram0_req.we    = 1'b1;
            ram0_req.addr  = clear_cnt_reg;
            ram0_req.wdata = OFF_CODE;
            ram1_req       = ram0_req;
        end else if (s_accept) begin
            unique case (req)
                REQ_WRITE: begin
                    pix_req.we = 1'b1;
                    if (line_index[HALF_W]) begin
                        ram1_req = pix_req;
                    end else begin
                        ram0_req = pix_req;
                    end
                end
                REQ_READ: begin
                    s1_new.is_read = 1'b1;
                    if (line_index[HALF_W]) begin
                        ram1_req = pix_req;
                    end else begin
                        ram0_req = pix_req;
                    end
                end
                REQ_TICK: begin
                    clock_pin_next     = !clock_pin_reg;
                    s1_new.clock_level = !clock_pin_reg;
                    if (!clock_pin_reg) begin
                        if (scan_pos_reg >= POS_W'(SCAN_LIMIT)) begin
                            scan_pos_next = '0;
                        end else begin
                            // Top pixel from the low bank, bottom from the high one
                            scan_pos_next  = scan_pos_reg + 1'b1;
                            s1_new.is_tick = 1'b1;
                            s1_new.latch   = (scan_offs == COL_W'(LINE_LENGTH - 1));
                            s1_new.row     = ROW_W'(scan_line);
                            ram0_req.en    = 1'b1;
                            ram0_req.addr  = {scan_line, scan_offs};
                            ram1_req       = ram0_req;
                        end
                    end
                end
                REQ_NONE: begin
                end
            endcase
        end
    end

    // Load an accepted beat into the empty or draining slot; drop a taken one
    always_comb begin
        s1_next = s1_reg;
        if (s_accept) begin
            s1_next = s1_new;
        end else if (s1_take) begin
            s1_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
            clock_pin_reg  <= 1'b0;
            scan_pos_reg   <= '0;
            s1_reg         <= '0;
        end else begin
            clear_busy_reg <= clear_busy_next;
            clear_cnt_reg  <= clear_cnt_next;
            clock_pin_reg  <= clock_pin_next;
            scan_pos_reg   <= scan_pos_next;
            s1_reg         <= s1_next;
        end
    end

endmodule

// File: hw/rtl/lmsd_pin_out.sv
// Output stage: colour decode, held pin state and result register.
module lmsd_pin_out
    import lmsd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lmsd_s1_t             s1,
    input  logic [COLOR_W-1:0]   rdata0,
    input  logic [COLOR_W-1:0]   rdata1,
    output logic                 s1_take,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [5:0]           color_pins_reg, color_pins_next;
    logic [ROW_W-1:0]     row_sel_reg, row_sel_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [COLOR_W-1:0]   read_color;

    assign s1_take  = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        color_pins_next = color_pins_reg;
        row_sel_next    = row_sel_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        read_color      = '0;
        if (s1.is_read) begin
            read_color = s1.bank ? rdata1 : rdata0;
        end
        if (s1_take) begin
            m_tvalid_next = s1.valid;
            if (s1.valid) begin
                if (s1.is_tick) begin
                    color_pins_next = {color_decode(rdata1), color_decode(rdata0)};
                    if (s1.latch) begin
                        row_sel_next = s1.row;
                    end
                end
                m_tdata_next = {3'b000, row_sel_next, s1.latch, color_pins_next,
                                s1.is_tick, s1.clock_level, read_color};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_pins_reg <= '0;
            row_sel_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            color_pins_reg <= color_pins_next;
            row_sel_reg    <= row_sel_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// File: hw/rtl/led_matrix_scan_driver_unit.sv
// Top level of the split-scan RGB LED panel driver with its frame store.
// Path: an accepted beat is registered in the s1 slot along with its bank read data,
// then moves into the result register on m_tdata once the output slot is free.
// Throughput: one beat per cycle unless m_tready stalls the output; each bank has a
// single port and every beat needs at most one access per bank, so the bank ports
// set the rate. Reset: a clearing pass writes the off code into both banks,
// with s_tready held low throughout; scan position, shift clock and pins go to zero.
module led_matrix_scan_driver_unit
    import lmsd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: line_index[4:0], position_index[10:5], pixel_color[18:11], zeros
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [REQ_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: read_color[7:0], clock_level[8], data_valid[9], top_red[10],
    // top_green[11], top_blue[12], bottom_red[13], bottom_green[14],
    // bottom_blue[15], latch_pulse[16], row_address[20:17], zeros
    output logic [M_TDATA_W-1:0] m_tdata
);

    lmsd_s1_t           s1;
    lmsd_ram_req_t      ram0_req, ram1_req;
    logic [COLOR_W-1:0] rdata0, rdata1;
    logic               s1_take;
    logic               clear_busy;

    // Issue bank accesses and track the scan for each accepted beat
    lmsd_scan_ctrl u_scan_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s1_take    (s1_take),
        .s1         (s1),
        .ram0_req   (ram0_req),
        .ram1_req   (ram1_req),
        .clear_busy (clear_busy)
    );

    // Low bank: store lines with bit 4 clear (top half of the panel)
    lmsd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank0 (
        .aclk  (aclk),
        .en    (ram0_req.en),
        .we    (ram0_req.we),
        .addr  (ram0_req.addr),
        .wdata (ram0_req.wdata),
        .rdata (rdata0)
    );

    // High bank: store lines with bit 4 set (bottom half of the panel)
    lmsd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank1 (
        .aclk  (aclk),
        .en    (ram1_req.en),
        .we    (ram1_req.we),
        .addr  (ram1_req.addr),
        .wdata (ram1_req.wdata),
        .rdata (rdata1)
    );

    // Decode read data, hold the pins and register the result beat
    lmsd_pin_out u_pin_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1       (s1),
        .rdata0   (rdata0),
        .rdata1   (rdata1),
        .s1_take  (s1_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // No beat enters while the clearing pass runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_tready)
        else $error("beat accepted during clearing pass");

    // A stalled item must keep its bank read data: no bank access meanwhile
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1.valid && !s1_take) |-> (!ram0_req.en && !ram1_req.en))
        else $error("bank accessed while read data is held");

    // Nothing waits on bank data before the store is cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s1.valid)
        else $error("item in flight during clearing pass");

endmodule
